// ===== design/sha_pkg.sv =====
// ============================================================================
// sha_pkg: shared types, constants and functions for the SHA-256 hasher
// Round constants, initial hash words, bit helpers and core control struct.
// ============================================================================
package sha_pkg;

    typedef logic [0:7][31:0]  t_words8;
    typedef logic [0:15][31:0] t_window;

    localparam t_words8 SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] SHA_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] LEN_START   = 6'd56;
    localparam logic [5:0] LAST_MARKED = 6'd55;
    localparam logic [5:0] BLOCK_LAST  = 6'd63;
    localparam logic [2:0] WORD_LAST   = 3'd7;

    // Control from the sequencer into the round engine
    typedef struct packed {
        logic       byte_we;     // shift one byte into the block window
        logic [7:0] data;
        logic       start;       // begin 64 rounds on the loaded block
        logic       chain_init;  // reload initial hash words
    } t_core_ctl;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== design/sha_if.sv =====
// ============================================================================
// sha_if: valid/ready channels of the SHA-256 hasher
// Input byte channel and digest word channel, each with source/sink modports.
// ============================================================================
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    modport source (output valid, digest_word, word_number, last_word, input ready);
    modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

// ===== design/sha_core.sv =====
// ============================================================================
// sha_core: SHA-256 round engine
// Block window, one round per cycle with in-place schedule, chain update.
// ============================================================================
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_core_ctl i_ctl,
    output logic               o_done,
    output sha_pkg::t_words8   o_chain
);
    import sha_pkg::*;

    t_window     r_win;
    logic [31:0] r_v [8];
    t_words8     r_chain;
    logic [5:0]  r_rnd;
    logic        r_run;
    logic        r_add;

    logic [511:0] win_flat;
    logic [31:0]  w_cur, w_new, t1, t2, ch, maj;

    always_comb begin
        win_flat = r_win;
        w_cur    = r_win[0];
        // W[t+16] from the sliding window
        w_new    = r_win[0] + small_sig0(r_win[1]) + r_win[9] + small_sig1(r_win[14]);
        ch       = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj      = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1       = r_v[7] + big_sig1(r_v[4]) + ch + SHA_K[r_rnd] + w_cur;
        t2       = big_sig0(r_v[0]) + maj;
    end

    // Control and chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_add   <= 1'b0;
            r_rnd   <= '0;
            r_chain <= SHA_IV;
        end else begin
            if (i_ctl.start) begin
                r_run <= 1'b1;
                r_rnd <= '0;
            end else if (r_run) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == BLOCK_LAST) begin
                    r_run <= 1'b0;
                    r_add <= 1'b1;
                end
            end
            if (r_add) begin
                r_add <= 1'b0;
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_v[i];
                end
            end
            if (i_ctl.chain_init) begin
                r_chain <= SHA_IV;
            end
        end
    end

    // Datapath: window and working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.byte_we) begin
            r_win <= {win_flat[503:0], i_ctl.data};
        end else if (r_run) begin
            r_win <= {r_win[1:15], w_new};
        end
        if (i_ctl.start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (r_run) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    assign o_done  = r_add;
    assign o_chain = r_chain;

endmodule

// ===== design/sha256_stream_hasher_top.sv =====
// ============================================================================
// sha256_stream_hasher_top: byte-stream SHA-256 hasher
// Gathers bytes into 64-byte blocks, pads on end of message, emits digest.
// ============================================================================
//  channel  | dir | payload                                   | word
//  i_in     | in  | data_byte[7:0], byte_present, end_of_msg  | one message byte / end
//  o_out    | out | digest_word[31:0], word_number[2:0], last | one digest word
//
//  Flow: a byte word is taken on valid while i_in.ready is high. The 64th byte of a
//  block runs the shared round engine: 64 rounds plus a chain add, with
//  i_in.ready low. End of message: pad and length bytes go in one per cycle
//  (up to 64, or 72 over two blocks), each block then compressed, then eight
//  digest words as o_out.ready allows; a stall holds the current word.
//  Reset loads the initial hash words, no clearing pass; busy until word 7 goes.
// ============================================================================
module sha256_stream_hasher_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);
    import sha_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,  // taking message bytes
        S_COMP,  // round engine busy
        S_PAD,   // feeding padding and length bytes
        S_OUT    // presenting digest words
    } t_state;

    typedef enum logic [1:0] {
        PH_MSG,  // block full of message bytes
        PH_PAD,  // padding under way, more blocks to come
        PH_DONE  // final block compressing
    } t_phase;

    t_state      r_state;
    t_phase      r_phase;
    logic [5:0]  r_fill;     // bytes held in the current block
    logic [60:0] r_msg;      // message length in bytes, wraps at 2^61
    logic        r_mark;     // 0x80 still to be written
    logic        r_lenblk;   // length field goes into this block
    logic [2:0]  r_onum;

    t_core_ctl   core_ctl;
    logic        core_done;
    t_words8     chain;

    logic        in_acc;
    logic        out_acc;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .o_done  (core_done),
        .o_chain (chain)
    );

    always_comb begin
        in_acc   = i_in.valid && (r_state == S_IDLE);
        out_acc  = o_out.ready && (r_state == S_OUT);
        bit_len  = {r_msg, 3'b000};
        // big-endian: byte 56 carries the top eight bits
        len_byte = bit_len[{~r_fill[2:0], 3'b000} +: 8];
        if (r_mark) begin
            pad_byte = PAD_MARK;
        end else if (r_lenblk && (r_fill >= LEN_START)) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = 8'h00;
        end

        core_ctl.byte_we    = (in_acc && i_in.byte_present) || (r_state == S_PAD);
        core_ctl.data       = (r_state == S_PAD) ? pad_byte : i_in.data_byte;
        core_ctl.start      = core_ctl.byte_we && (r_fill == BLOCK_LAST);
        core_ctl.chain_init = out_acc && (r_onum == WORD_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_MSG;
            r_fill   <= '0;
            r_msg    <= '0;
            r_mark   <= 1'b0;
            r_lenblk <= 1'b0;
            r_onum   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.byte_present) begin
                            r_fill <= r_fill + 6'd1;
                            r_msg  <= r_msg + 61'd1;
                        end
                        if (i_in.byte_present && (r_fill == BLOCK_LAST)) begin
                            r_state <= S_COMP;
                            r_phase <= i_in.end_of_message ? PH_PAD : PH_MSG;
                            r_mark  <= i_in.end_of_message;
                        end else if (i_in.end_of_message) begin
                            r_state <= S_PAD;
                            r_phase <= PH_PAD;
                            r_mark  <= 1'b1;
                        end
                    end
                end
                S_PAD: begin
                    r_fill <= r_fill + 6'd1;
                    if (r_mark) begin
                        r_mark   <= 1'b0;
                        r_lenblk <= (r_fill <= LAST_MARKED);
                    end
                    if (r_fill == BLOCK_LAST) begin
                        r_state <= S_COMP;
                        if (r_lenblk && !r_mark) begin
                            r_phase <= PH_DONE;
                        end
                    end
                end
                S_COMP: begin
                    if (core_done) begin
                        unique case (r_phase)
                            PH_MSG: begin
                                r_state <= S_IDLE;
                            end
                            PH_PAD: begin
                                r_state  <= S_PAD;
                                r_lenblk <= 1'b1;
                            end
                            PH_DONE: begin
                                r_state <= S_OUT;
                                r_onum  <= '0;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_onum <= r_onum + 3'd1;
                        if (r_onum == WORD_LAST) begin
                            r_state  <= S_IDLE;
                            r_phase  <= PH_MSG;
                            r_msg    <= '0;
                            r_lenblk <= 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.digest_word = chain[r_onum];
    assign o_out.word_number = r_onum;
    assign o_out.last_word   = (r_onum == WORD_LAST);

endmodule

// ===== tb/sha256_stream_hasher_checker.sv =====
// ============================================================================
// sha256_stream_hasher_checker: digest predictor and scoreboard
// Watches both channels and recomputes SHA-256 over the accepted byte words.
// It compares every digest word taken from the block against the queue of
// predicted words.
// ============================================================================
module sha256_stream_hasher_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sha_in_if    i_in_mon,
    sha_out_if   i_out_mon,
    output int   o_err_count,
    output int   o_pending,
    output int   o_words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [0:7][31:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  index;
        logic        last;
    } t_digest_exp;

    // predictor state
    logic [31:0] chain_h [8];
    logic [7:0]  blk [64];
    int unsigned blk_fill;
    logic [60:0] msg_len;

    t_digest_exp digest_q [$];
    t_digest_exp want, got;
    int          errs;
    int          checked;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    function automatic void init_state();
        for (int k = 0; k < 8; k++) chain_h[k] = H_INIT[k];
        blk_fill = 0;
        msg_len  = '0;
    endfunction

    function automatic void compress_blk();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] s0, s1, ch, maj, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int t = 0; t < 64; t++) begin
            s1  = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
            ch  = (e & f) ^ (~e & g);
            t1  = h + s1 + ch + ROUND_K[t] + w[t];
            s0  = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
            maj = (a & b) ^ (a & c) ^ (b & c);
            t2  = s0 + maj;
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    // one accepted word: absorb the byte, then pad and queue the digest on end
    function automatic void absorb(input logic [7:0] data, input logic has_byte,
                                   input logic at_end);
        logic [63:0] bit_len;
        t_digest_exp nxt;
        if (has_byte) begin
            blk[blk_fill] = data;
            blk_fill++;
            msg_len++;
            if (blk_fill == 64) begin
                compress_blk();
                blk_fill = 0;
            end
        end
        if (at_end) begin
            bit_len = {msg_len, 3'b000};
            blk[blk_fill] = 8'h80;
            for (int p = blk_fill + 1; p < 64; p++) blk[p] = 8'h00;
            // marker lands inside the length field: spill into a second block
            if (blk_fill >= 56) begin
                compress_blk();
                for (int p = 0; p < 64; p++) blk[p] = 8'h00;
            end
            for (int k = 0; k < 8; k++) blk[56+k] = bit_len[63-8*k -: 8];
            compress_blk();
            for (int k = 0; k < 8; k++) begin
                nxt.value = chain_h[k];
                nxt.index = 3'(k);
                nxt.last  = (k == 7);
                digest_q  = {digest_q, nxt};
            end
            init_state();
        end
    endfunction

    initial begin
        errs    = 0;
        checked = 0;
        init_state();
    end

    // outputs are scored before inputs: a word leaving on this edge can never
    // belong to a byte word accepted on the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            init_state();
            digest_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.value = i_out_mon.digest_word;
                got.index = i_out_mon.word_number;
                got.last  = i_out_mon.last_word;
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest word %h index %0d last %0b, none expected",
                             $time, got.value, got.index, got.last);
                    errs++;
                end else begin
                    want = digest_q.pop_front();
                    checked++;
                    if (got.value !== want.value) begin
                        $display("%0t: digest_word expected %h, got %h",
                                 $time, want.value, got.value);
                        errs++;
                    end
                    if (got.index !== want.index) begin
                        $display("%0t: word_number expected %0d, got %0d",
                                 $time, want.index, got.index);
                        errs++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_word expected %0b, got %0b",
                                 $time, want.last, got.last);
                        errs++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                absorb(i_in_mon.data_byte, i_in_mon.byte_present, i_in_mon.end_of_message);
        end
        o_err_count     <= errs;
        o_pending       <= digest_q.size();
        o_words_checked <= checked;
    end

endmodule

// ===== tb/sha256_stream_hasher_top_test.sv =====
// ============================================================================
// sha256_stream_hasher_top_test: stimulus and verdict for the SHA-256 hasher
// Directed messages (empty, byte with end, ignored words, a long output stall)
// then random-content messages at the padding boundaries and random lengths,
// all under bursty input and a stalling digest receiver.
// ============================================================================
module sha256_stream_hasher_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 460;     // byte/end words for the whole run
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int DRAIN_CYCLES = 300;     // > two-block padding + 8 words
    localparam int TIMEOUT_NS   = 1000000;

    logic i_clk;
    logic i_rst_n;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    int err_count;
    int pending;
    int words_checked;

    // sender bookkeeping
    int items_sent;
    int bytes_sent;
    int msgs_sent;
    int noop_sent;
    int longest_msg;
    int burst_left;

    // asks the receiver for one long hold-off; it clears the flag itself
    bit hold_request;

    sha256_stream_hasher_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sha256_stream_hasher_checker checker_u (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_err_count     (err_count),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("sha256_stream_hasher_top_test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Digest receiver. Runs through modes of its own (always ready, coin toss,
    // ready when its phase count is a multiple of four, mostly ready), each for
    // a random stretch. On request it holds ready low through a long hold-off
    // counted here, so the block finishes a digest, cannot hand it over and in
    // turn refuses further byte words.
    initial begin
        int hold_cnt;
        int mode;
        int mode_left;
        int phase;
        hold_cnt  = 0;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_cnt     = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 150);
                end
                mode_left--;
                case (mode)
                    0: begin
                        out_ch.ready <= 1'b1;
                    end
                    1: begin
                        out_ch.ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        out_ch.ready <= (phase % 4 == 0);
                    end
                    default: begin
                        out_ch.ready <= ($urandom_range(0, 3) != 0);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Offer one word and wait for it to be taken. Words go out in bursts of
    // random length; between bursts valid drops for a random gap, and about a
    // third of the bursts run straight on with no gap. Valid stays high from
    // one word to the next inside a burst, so it is only ever assigned once
    // per edge.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] data, input logic has_byte,
                             input logic at_end);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= data;
        in_ch.byte_present   <= has_byte;
        in_ch.end_of_message <= at_end;
        do @(posedge i_clk); while (!in_ch.ready);
        if (has_byte || at_end) items_sent++;
        else noop_sent++;
        if (has_byte) bytes_sent++;
    endtask

    // A message of random bytes. The end either rides on the last byte or
    // follows as a word of its own (random, ignored data); an empty message
    // is a lone end word. With noise on, stray do-nothing words are slipped
    // in among the bytes.
    task automatic send_message(input int len, input bit end_on_byte,
                                input bit with_noise);
        bit tail;
        for (int n = 0; n < len; n++) begin
            if (with_noise && $urandom_range(0, 19) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            tail = end_on_byte && (n == len - 1);
            send_word(8'($urandom_range(0, 255)), 1'b1, tail);
        end
        if (len == 0 || !end_on_byte)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        msgs_sent++;
        if (len > longest_msg) longest_msg = len;
    endtask

    initial begin
        items_sent   = 0;
        bytes_sent   = 0;
        msgs_sent    = 0;
        noop_sent    = 0;
        longest_msg  = 0;
        burst_left   = 0;
        hold_request = 1'b0;

        in_ch.valid          <= 1'b0;
        in_ch.data_byte      <= 8'h00;
        in_ch.byte_present   <= 1'b0;
        in_ch.end_of_message <= 1'b0;
        i_rst_n              <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ------------------------------------------------------
        // empty message: a lone end word straight after reset
        send_word(8'h00, 1'b0, 1'b1);
        msgs_sent++;

        // "abc", end carried on the final byte
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        msgs_sent++;

        // do-nothing word with all data bits set, then the byte extremes and
        // a separate end word whose data must be ignored
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h5a, 1'b0, 1'b1);
        msgs_sent++;
        if (longest_msg < 3) longest_msg = 3;

        // back-pressure: receiver stops for a long stretch while the next
        // message keeps coming, so the input side must stall behind it
        hold_request = 1'b1;
        send_message(3, 1'b1, 1'b0);
        send_message(6, 1'b0, 1'b0);

        // ---- random --------------------------------------------------------
        // lengths that put the pad marker at the last single-block slot, force
        // a second padding block, end a block exactly, and cross a block
        send_message(55, 1'($urandom_range(0, 1)), 1'b1);
        send_message(56, 1'($urandom_range(0, 1)), 1'b1);
        send_message(63, 1'($urandom_range(0, 1)), 1'b1);
        send_message(64, 1'($urandom_range(0, 1)), 1'b1);
        send_message(120, 1'($urandom_range(0, 1)), 1'b1);

        // then mostly short messages with the odd longer one
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0)
                send_message($urandom_range(0, 70), 1'($urandom_range(0, 1)), 1'b1);
            else
                send_message($urandom_range(0, 12), 1'($urandom_range(0, 1)), 1'b1);
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);

        // drain, then keep watching for stray digest words
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d messages (%0d bytes, longest %0d, %0d ignored words)",
                 msgs_sent, bytes_sent, longest_msg, noop_sent);
        $display("checked %0d digest words, one %0d-cycle receiver hold-off",
                 words_checked, HOLD_CYCLES);
        if (err_count == 0 && pending == 0) begin
            $display("sha256_stream_hasher_top_test passed");
        end else begin
            $display("sha256_stream_hasher_top_test failed");
        end
        $finish;
    end

endmodule
